// ===== src/qrbm_pkg.sv =====
// Shared types and constants for the quartic ring base multiplier.
package qrbm_pkg;

  localparam logic signed [15:0] QModulus = 16'sd3457;
  localparam logic [15:0] QNegInv = 16'hCD7F;

  localparam int NumStages = 8;

  typedef struct packed {
    logic signed [15:0] a_coef0;
    logic signed [15:0] a_coef1;
    logic signed [15:0] a_coef2;
    logic signed [15:0] a_coef3;
    logic signed [15:0] b_coef0;
    logic signed [15:0] b_coef1;
    logic signed [15:0] b_coef2;
    logic signed [15:0] b_coef3;
    logic signed [15:0] zeta;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] prod_coef0;
    logic signed [15:0] prod_coef1;
    logic signed [15:0] prod_coef2;
    logic signed [15:0] prod_coef3;
  } out_word_t;

  typedef struct packed {
    logic low_step;
    logic high_step;
  } mont_en_t;

endpackage

// ===== src/qrbm_mont.sv =====
// Two-stage Montgomery reduction of one 32-bit accumulator.
module qrbm_mont (
  input  logic               clk,
  input  qrbm_pkg::mont_en_t en,
  input  logic [31:0]        acc,
  output logic signed [15:0] res
);
  import qrbm_pkg::*;

  logic [31:0] acc_q;
  logic [15:0] t_q;
  logic [15:0] t_next;
  logic signed [31:0] tq_prod;
  logic [31:0] sum;

  assign t_next = acc[15:0] * QNegInv;
  assign tq_prod = $signed(t_q) * QModulus;
  assign sum = acc_q + $unsigned(tq_prod);

  always_ff @(posedge clk) begin
    if (en.low_step) begin
      acc_q <= acc;
      t_q <= t_next;
    end
    if (en.high_step) begin
      res <= $signed(sum[31:16]);
    end
  end

endmodule

// ===== src/quartic_ring_base_multiply.sv =====
// Top level of the quartic ring base multiplier with Montgomery reduction.
// Throughput is one word per cycle unless the output stalls; each pipeline stage holds
// while full and blocked, and empty stages fill behind a stalled output.
// Reset is synchronous and clears only the stage valid bits.
module quartic_ring_base_multiply (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qrbm_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output qrbm_pkg::out_word_t out_word
);
  import qrbm_pkg::*;

  logic [NumStages:1] v;
  logic [NumStages:1] en;

  logic signed [15:0] av [4];
  logic signed [15:0] bv [4];

  logic signed [31:0] p1 [16];
  logic signed [15:0] z1, z2, z3, z4;
  logic [31:0] hs2 [3];
  logic [31:0] l2 [4];
  logic [31:0] l3 [3];
  logic [31:0] l4 [3];
  logic [31:0] l5 [3];
  logic signed [15:0] m4 [4];
  logic [31:0] hz5 [3];
  logic [31:0] acc6 [3];
  logic signed [15:0] m8 [3];
  logic signed [15:0] r3_5, r3_6, r3_7, r3_8;
  logic [31:0] mont_a_in [4];

  mont_en_t en_a;
  mont_en_t en_b;

  assign av[0] = in_word.a_coef0;
  assign av[1] = in_word.a_coef1;
  assign av[2] = in_word.a_coef2;
  assign av[3] = in_word.a_coef3;
  assign bv[0] = in_word.b_coef0;
  assign bv[1] = in_word.b_coef1;
  assign bv[2] = in_word.b_coef2;
  assign bv[3] = in_word.b_coef3;

  always_comb begin
    en[NumStages] = !v[NumStages] || out_ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[1];
  assign out_valid = v[NumStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Partial products and sums of the high and low halves.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1[i*4+j] <= av[i] * bv[j];
        end
      end
      z1 <= in_word.zeta;
    end
    if (en[2]) begin
      hs2[0] <= $unsigned(p1[7]) + $unsigned(p1[10]) + $unsigned(p1[13]);
      hs2[1] <= $unsigned(p1[11]) + $unsigned(p1[14]);
      hs2[2] <= $unsigned(p1[15]);
      l2[0] <= $unsigned(p1[0]);
      l2[1] <= $unsigned(p1[1]) + $unsigned(p1[4]);
      l2[2] <= $unsigned(p1[2]) + $unsigned(p1[5]) + $unsigned(p1[8]);
      l2[3] <= $unsigned(p1[3]) + $unsigned(p1[6]) + $unsigned(p1[9]) + $unsigned(p1[12]);
      z2 <= z1;
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        l3[i] <= l2[i];
      end
      z3 <= z2;
    end
    if (en[4]) begin
      l4 <= l3;
      z4 <= z3;
    end
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        hz5[i] <= $unsigned(32'(m4[i] * z4));
      end
      l5 <= l4;
      r3_5 <= m4[3];
    end
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        acc6[i] <= hz5[i] + l5[i];
      end
      r3_6 <= r3_5;
    end
    if (en[7]) begin
      r3_7 <= r3_6;
    end
    if (en[8]) begin
      r3_8 <= r3_7;
    end
  end

  assign en_a.low_step = en[3];
  assign en_a.high_step = en[4];
  assign en_b.low_step = en[7];
  assign en_b.high_step = en[8];

  assign mont_a_in[0] = hs2[0];
  assign mont_a_in[1] = hs2[1];
  assign mont_a_in[2] = hs2[2];
  assign mont_a_in[3] = l2[3];

  for (genvar g = 0; g < 4; g++) begin : g_mont_a
    qrbm_mont u_mont (
      .clk (clk),
      .en  (en_a),
      .acc (mont_a_in[g]),
      .res (m4[g])
    );
  end

  for (genvar g = 0; g < 3; g++) begin : g_mont_b
    qrbm_mont u_mont (
      .clk (clk),
      .en  (en_b),
      .acc (acc6[g]),
      .res (m8[g])
    );
  end

  assign out_word.prod_coef0 = m8[0];
  assign out_word.prod_coef1 = m8[1];
  assign out_word.prod_coef2 = m8[2];
  assign out_word.prod_coef3 = r3_8;

endmodule

// ===== src/qrbm_check.sv =====
// Port-level checker for the quartic ring base multiplier and its bind.
module qrbm_check (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input qrbm_pkg::out_word_t out_word
);
  import qrbm_pkg::*;

  // A blocked output word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // An empty output stage never blocks the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A draining output never blocks the input.
  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind quartic_ring_base_multiply qrbm_check u_qrbm_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
